### src/assert_macros.svh
// Assertion helpers shared by the RTL.
// All checks are sampled on aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

### src/md5_pkg.sv
// ---------------------------------------------------------------------------
// md5_pkg
// Shared payload types, command/status structs and MD5 constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package md5_pkg;

    localparam logic [1:0] FUNC_APPEND = 2'd0;
    localparam logic [1:0] FUNC_FINAL  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] FILL_MAX = 6'h3F;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic       accept;    // input request taken this cycle
        logic       start;     // load working vars
        logic       step;      // one compression step
        logic       finish;    // fold working vars into hash
        logic       use_hw;    // finalize copy instead of running chain
        logic       has_data;  // buffer bytes and pad mark present
        logic       has_len;   // bit count in bytes 56..63
        logic [5:0] step_idx;
        logic [1:0] word_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fill_last;  // next append completes the block
        logic pad_two;    // padding needs an extra block
    } stat_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

endpackage

### src/md5_stream_hasher.sv
// ---------------------------------------------------------------------------
// md5_stream_hasher
// Byte-serial MD5 with non-destructive finalize and clear.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    md5_pkg::in_t  {func, data_byte}
// m_       out  m_valid/m_ready    md5_pkg::out_t {digest_word, word_index, last_word}
//
// The byte that fills the block also starts a compression
// (load, 64 rounds of the single step unit, fold).
// Finalize runs one such block, or two when 56 or more bytes are buffered, then 4 words.
// s_ready is low while a block runs and while digest words are presented.
// Reset (aresetn low, synchronous) restores the initial chaining words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_stream_hasher (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  md5_pkg::in_t   s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output md5_pkg::out_t  m_payload
);

    md5_pkg::cmd_t  cmd;
    md5_pkg::stat_t stat;
    logic [31:0]    digest;

    md5_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_payload.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    md5_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_payload),
        .cmd     (cmd),
        .stat    (stat),
        .digest  (digest)
    );

    assign m_payload.digest_word = digest;
    assign m_payload.word_index  = cmd.word_sel;
    assign m_payload.last_word   = (cmd.word_sel == 2'd3);

endmodule

### src/md5_ctrl.sv
// ---------------------------------------------------------------------------
// md5_ctrl
// Sequencer: request decode, block step counter and digest readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module md5_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    output logic              m_valid,
    input  logic              m_ready,
    input  md5_pkg::stat_t    stat,
    output md5_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_DONE,
        ST_OUT
    } state_t;

    state_t     state_reg;
    logic       fin_reg;   // block belongs to a finalize
    logic       two_reg;   // finalize spans two blocks
    logic       sec_reg;   // working on the second of two
    logic [5:0] cnt_reg;
    logic [1:0] widx_reg;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd          = '0;
        cmd.accept   = accept;
        cmd.start    = (state_reg == ST_LOAD);
        cmd.step     = (state_reg == ST_RUN);
        cmd.finish   = (state_reg == ST_DONE);
        cmd.use_hw   = fin_reg;
        cmd.has_data = !sec_reg;
        cmd.has_len  = !(two_reg && !sec_reg);
        cmd.step_idx = cnt_reg;
        cmd.word_sel = widx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            sec_reg   <= 1'b0;
            cnt_reg   <= '0;
            widx_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_func == md5_pkg::FUNC_APPEND && stat.fill_last) begin
                            fin_reg   <= 1'b0;
                            two_reg   <= 1'b0;
                            sec_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end else if (s_func == md5_pkg::FUNC_FINAL) begin
                            fin_reg   <= 1'b1;
                            two_reg   <= stat.pad_two;
                            sec_reg   <= 1'b0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    cnt_reg   <= '0;
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == md5_pkg::FILL_MAX) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!fin_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (two_reg && !sec_reg) begin
                        sec_reg   <= 1'b1;
                        state_reg <= ST_LOAD;
                    end else begin
                        widx_reg  <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        widx_reg <= widx_reg + 2'd1;
                        if (widx_reg == 2'd3) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_out_blocks_in, m_valid && s_ready, "input taken during readout")
    `ASSERT_CLK(a_run_ends, (state_reg == ST_RUN && cnt_reg == md5_pkg::FILL_MAX) |=> (state_reg == ST_DONE), "block did not end after 64 steps")
    `ASSERT_CLK(a_last_word_idle, (m_valid && m_ready && widx_reg == 2'd3) |=> s_ready, "no return to idle after last word")
    `ASSERT_CLK(a_second_only_two, sec_reg |-> two_reg, "second block without two-block padding")

endmodule

### src/md5_dp.sv
// ---------------------------------------------------------------------------
// md5_dp
// Datapath: block buffer, counters, chaining words and one MD5 step per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module md5_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  md5_pkg::in_t    s_data,
    input  md5_pkg::cmd_t   cmd,
    output md5_pkg::stat_t  stat,
    output logic [31:0]     digest
);

    logic [31:0] buf_reg [16];
    logic [31:0] chain_reg [4];
    logic [31:0] hw_reg [4];
    logic [63:0] bits_reg;
    logic [5:0]  fill_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;

    logic [1:0]  rnd;
    logic [3:0]  i4;
    logic [3:0]  g;
    logic [31:0] f;
    logic [31:0] w;
    logic [31:0] t;
    logic [63:0] rot;
    logic [5:0]  j [4];
    logic [31:0] raw;

    assign stat.fill_last = (fill_reg == md5_pkg::FILL_MAX);
    assign stat.pad_two   = (fill_reg >= md5_pkg::LEN_POS);
    assign digest         = hw_reg[cmd.word_sel];

    assign rnd = cmd.step_idx[5:4];
    assign i4  = cmd.step_idx[3:0];
    assign raw = buf_reg[g];

    always_comb begin
        unique case (rnd)
            2'd0: begin
                f = d_reg ^ (b_reg & (c_reg ^ d_reg));
                g = i4;
            end
            2'd1: begin
                f = c_reg ^ (d_reg & (b_reg ^ c_reg));
                g = (i4 << 2) + i4 + 4'd1;
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = (i4 << 1) + i4 + 4'd5;
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = (i4 << 3) - i4;
            end
        endcase
    end

    // message word with padding applied per byte
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            j[k] = {g, 2'(k)};
            if (!cmd.use_hw || (cmd.has_data && j[k] < fill_reg)) begin
                w[8*k +: 8] = raw[8*k +: 8];
            end else if (cmd.has_data && j[k] == fill_reg) begin
                w[8*k +: 8] = md5_pkg::PAD_MARK;
            end else if (cmd.has_len && j[k] >= md5_pkg::LEN_POS) begin
                w[8*k +: 8] = bits_reg[8*j[k][2:0] +: 8];
            end else begin
                w[8*k +: 8] = 8'h00;
            end
        end
    end

    assign t   = a_reg + f + w + md5_pkg::K_TAB[cmd.step_idx];
    assign rot = {t, t} << md5_pkg::ROT_TAB[{rnd, i4[1:0]}];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg[0] <= md5_pkg::IV_A;
            chain_reg[1] <= md5_pkg::IV_B;
            chain_reg[2] <= md5_pkg::IV_C;
            chain_reg[3] <= md5_pkg::IV_D;
            bits_reg     <= '0;
            fill_reg     <= '0;
        end else begin
            if (cmd.accept) begin
                unique case (s_data.func)
                    md5_pkg::FUNC_APPEND: begin
                        bits_reg <= bits_reg + 64'd8;
                        fill_reg <= fill_reg + 6'd1;
                    end
                    md5_pkg::FUNC_CLEAR: begin
                        chain_reg[0] <= md5_pkg::IV_A;
                        chain_reg[1] <= md5_pkg::IV_B;
                        chain_reg[2] <= md5_pkg::IV_C;
                        chain_reg[3] <= md5_pkg::IV_D;
                        bits_reg     <= '0;
                        fill_reg     <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.finish && !cmd.use_hw) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && s_data.func == md5_pkg::FUNC_APPEND) begin
            buf_reg[fill_reg[5:2]][8*fill_reg[1:0] +: 8] <= s_data.data_byte;
        end
        if (cmd.accept && s_data.func == md5_pkg::FUNC_FINAL) begin
            hw_reg <= chain_reg;
        end else if (cmd.finish && cmd.use_hw) begin
            hw_reg[0] <= hw_reg[0] + a_reg;
            hw_reg[1] <= hw_reg[1] + b_reg;
            hw_reg[2] <= hw_reg[2] + c_reg;
            hw_reg[3] <= hw_reg[3] + d_reg;
        end
        if (cmd.start) begin
            a_reg <= cmd.use_hw ? hw_reg[0] : chain_reg[0];
            b_reg <= cmd.use_hw ? hw_reg[1] : chain_reg[1];
            c_reg <= cmd.use_hw ? hw_reg[2] : chain_reg[2];
            d_reg <= cmd.use_hw ? hw_reg[3] : chain_reg[3];
        end else if (cmd.step) begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot[63:32];
        end
    end

endmodule
